// ----- design/ppg_pkg.sv -----
// Shared types, constants and constant tables of the plasma pixel generator.
// Depends on nothing; every other file imports it.
`default_nettype none
package ppg_pkg;

  localparam int COL_W    = 8;
  localparam int TIME_W   = 24;
  localparam int DIM_W    = 9;
  localparam int COEF_W   = 23;
  localparam int ANGLE_W  = 24;
  localparam int SIDX_W   = 10;
  localparam int SINE_W   = 16;
  localparam int SUM3_W   = 17;
  localparam int PHASE_W  = 17;
  localparam int SQ_W     = 21;
  localparam int DIST_W   = 19;
  localparam int SLOT_W   = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  localparam int PALETTE_ENTRIES = 14;
  localparam int QUARTER         = 256;

  localparam int FRONT_STAGES = 5;
  localparam int ISQRT_STEPS  = 19;
  localparam int BACK_STAGES  = 5;
  localparam int LATENCY      = FRONT_STAGES + ISQRT_STEPS + BACK_STAGES;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_PRESET   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_THEME  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 8'd3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd80;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd24;

  // floor((2^32 - 1) / 5): quotient estimate is low by at most one
  localparam logic [29:0] RECIP5 = 30'd858993459;

  localparam logic [1:0] BRT_DIM = 2'd0;
  localparam logic [1:0] BRT_NRM = 2'd1;
  localparam logic [1:0] BRT_BLD = 2'd2;

  localparam logic [7:0] G_DOT   = 8'h2E;
  localparam logic [7:0] G_COLON = 8'h3A;
  localparam logic [7:0] G_PLUS  = 8'h2B;
  localparam logic [7:0] G_STAR  = 8'h2A;
  localparam logic [7:0] G_HASH  = 8'h23;
  localparam logic [7:0] G_AT    = 8'h40;

  typedef struct packed {
    logic [2:0] colour;
    logic [1:0] bright;
    logic [7:0] glyph;
  } stop_t;

  typedef struct packed {
    logic signed [SUM3_W-1:0] sum3;
    logic [PHASE_W-1:0]       phase;
    logic [ANGLE_W-1:0]       tterm4;
  } side_t;

  typedef logic [14:0] qsine_tab_t [0:QUARTER];

  // rad/s or rad/cell in hundredths -> turns in Q0.24, rounded
  function automatic logic [COEF_W-1:0] turns(input int h);
    longint unsigned v;
    v = (longint'(h) * 64'd26701768 + 64'd500) / 64'd1000;
    return COEF_W'(v);
  endfunction

  // Quarter-wave sine, Q1.14, from a Q30 Taylor series up to x^9
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    longint unsigned u, x, x2, t;
    for (int i = 0; i <= QUARTER; i++) begin
      u  = 64'(2 * i);
      x  = (u * 64'd3373259426) / 64'd1024;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 64'd72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
      tab[i] = 15'((((x * t) >> 30) + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

  function automatic logic signed [SINE_W-1:0] sine_at(input logic [SIDX_W-1:0] idx);
    logic [8:0] k;
    logic [8:0] q;
    logic signed [SINE_W-1:0] mag;
    k = idx[8:0];
    q = (k > 9'd256) ? 9'(10'd512 - 10'(k)) : k;
    mag = SINE_W'(QSINE[q]);
    return idx[9] ? -mag : mag;
  endfunction

  localparam logic [COEF_W-1:0] F_COEF [4][4] = '{
    '{turns(20), turns(25), turns(15), turns(18)},
    '{turns(40), turns(35), turns(30), turns(22)},
    '{turns(10), turns(12), turns(8),  turns(9)},
    '{turns(35), turns(28), turns(45), turns(20)}};

  localparam logic [COEF_W-1:0] S_COEF [4][4] = '{
    '{turns(100), turns(80),  turns(120), turns(90)},
    '{turns(150), turns(130), turns(180), turns(120)},
    '{turns(40),  turns(30),  turns(50),  turns(35)},
    '{turns(200), turns(180), turns(220), turns(160)}};

  localparam stop_t THEMES [4][PALETTE_ENTRIES] = '{
    '{'{3'd6,BRT_DIM,G_DOT},  '{3'd6,BRT_NRM,G_COLON}, '{3'd5,BRT_NRM,G_PLUS},
      '{3'd5,BRT_BLD,G_PLUS}, '{3'd4,BRT_NRM,G_PLUS},  '{3'd4,BRT_BLD,G_STAR},
      '{3'd3,BRT_NRM,G_STAR}, '{3'd3,BRT_BLD,G_STAR},  '{3'd2,BRT_BLD,G_HASH},
      '{3'd2,BRT_NRM,G_HASH}, '{3'd1,BRT_BLD,G_HASH},  '{3'd1,BRT_NRM,G_COLON},
      '{3'd7,BRT_NRM,G_DOT},  '{3'd7,BRT_DIM,G_DOT}},
    '{'{3'd1,BRT_DIM,G_DOT},  '{3'd1,BRT_DIM,G_DOT},   '{3'd1,BRT_NRM,G_COLON},
      '{3'd1,BRT_BLD,G_COLON},'{3'd2,BRT_DIM,G_PLUS},  '{3'd2,BRT_NRM,G_PLUS},
      '{3'd2,BRT_BLD,G_STAR}, '{3'd2,BRT_BLD,G_STAR},  '{3'd3,BRT_DIM,G_HASH},
      '{3'd3,BRT_NRM,G_HASH}, '{3'd3,BRT_BLD,G_HASH},  '{3'd3,BRT_BLD,G_AT},
      '{3'd3,BRT_BLD,G_AT},   '{3'd3,BRT_BLD,G_AT}},
    '{'{3'd6,BRT_DIM,G_DOT},  '{3'd6,BRT_DIM,G_DOT},   '{3'd6,BRT_NRM,G_COLON},
      '{3'd6,BRT_NRM,G_COLON},'{3'd6,BRT_BLD,G_COLON}, '{3'd5,BRT_DIM,G_PLUS},
      '{3'd5,BRT_NRM,G_PLUS}, '{3'd5,BRT_BLD,G_STAR},  '{3'd5,BRT_BLD,G_HASH},
      '{3'd4,BRT_DIM,G_HASH}, '{3'd4,BRT_NRM,G_HASH},  '{3'd4,BRT_BLD,G_AT},
      '{3'd4,BRT_BLD,G_AT},   '{3'd4,BRT_BLD,G_AT}},
    '{'{3'd4,BRT_DIM,G_DOT},  '{3'd4,BRT_DIM,G_DOT},   '{3'd4,BRT_DIM,G_COLON},
      '{3'd4,BRT_NRM,G_COLON},'{3'd4,BRT_NRM,G_PLUS},  '{3'd4,BRT_NRM,G_PLUS},
      '{3'd4,BRT_NRM,G_STAR}, '{3'd4,BRT_BLD,G_STAR},  '{3'd4,BRT_BLD,G_HASH},
      '{3'd4,BRT_BLD,G_HASH}, '{3'd4,BRT_BLD,G_AT},    '{3'd4,BRT_BLD,G_AT},
      '{3'd4,BRT_BLD,G_AT},   '{3'd4,BRT_BLD,G_AT}}};

endpackage
`default_nettype wire

// ----- design/plasma_pixel_generator.sv -----
// Top level of the plasma pixel generator: configuration registers and the
// front, square-root and back pipelines. Depends on ppg_pkg and all ppg_ modules.
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        cell_column, cell_row, elapsed_time
//  result    out        done (one cycle)     palette_slot, colour_pair, brightness,
//                                            glyph_code
//  config    in         cfg_valid&cfg_ready  cfg_index, cfg_data
//
// One request per clock; each result passes through 5 front stages,
// 19 square-root stages and 5 back stages.
// busy is high only during reset; the pipeline never stalls, results are
// presented once and cannot be held off. Reset clears valid bits and the
// configuration registers.
`default_nettype none
module plasma_pixel_generator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [ppg_pkg::COL_W-1:0]        cell_column,
  input  wire logic [ppg_pkg::COL_W-1:0]        cell_row,
  input  wire logic [ppg_pkg::TIME_W-1:0]       elapsed_time,
  output logic                                  done,
  output logic [ppg_pkg::SLOT_W-1:0]            palette_slot,
  output logic [2:0]                            colour_pair,
  output logic [1:0]                            brightness,
  output logic [7:0]                            glyph_code,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ppg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppg_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ppg_pkg::*;

  logic [1:0]       wave_preset, colour_theme;
  logic [DIM_W-1:0] screen_width, screen_height;

  logic             f_valid, q_valid;
  logic [SQ_W-1:0]  f_sq;
  side_t            f_side, q_side;
  logic [DIST_W-1:0] q_dist;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_preset   <= '0;
      colour_theme  <= '0;
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes to unknown indexes
      unique case (cfg_index)
        REG_WAVE_PRESET:   wave_preset   <= cfg_data[1:0];
        REG_COLOUR_THEME:  colour_theme  <= cfg_data[1:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  ppg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .col_in    (cell_column),
    .row_in    (cell_row),
    .time_in   (elapsed_time),
    .preset    (wave_preset),
    .width     (screen_width),
    .height    (screen_height),
    .out_valid (f_valid),
    .sq_out    (f_sq),
    .side_out  (f_side)
  );

  ppg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .sq_in     (f_sq),
    .side_in   (f_side),
    .out_valid (q_valid),
    .dist_out  (q_dist),
    .side_out  (q_side)
  );

  ppg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .dist_in  (q_dist),
    .side_in  (q_side),
    .preset   (wave_preset),
    .theme    (colour_theme),
    .done     (done),
    .slot     (palette_slot),
    .colour   (colour_pair),
    .bright   (brightness),
    .glyph    (glyph_code)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    1'b1 |-> ##LATENCY (done == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match request timing");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    done |-> palette_slot <= SLOT_W'(PALETTE_ENTRIES - 1))
    else $error("palette slot out of range");

  a_cfg_width: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == REG_SCREEN_WIDTH |=>
      screen_width == $past(cfg_data))
    else $error("screen width write lost");

endmodule
`default_nettype wire

// ----- design/ppg_front.sv -----
// Front stages: offsets and squares, linear wave angles, palette phase,
// three sine lookups and their sum. Depends on ppg_pkg.
`default_nettype none
module ppg_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [ppg_pkg::COL_W-1:0]   col_in,
  input  wire logic [ppg_pkg::COL_W-1:0]   row_in,
  input  wire logic [ppg_pkg::TIME_W-1:0]  time_in,
  input  wire logic [1:0]                  preset,
  input  wire logic [ppg_pkg::DIM_W-1:0]   width,
  input  wire logic [ppg_pkg::DIM_W-1:0]   height,
  output logic                             out_valid,
  output logic [ppg_pkg::SQ_W-1:0]         sq_out,
  output ppg_pkg::side_t                   side_out
);
  import ppg_pkg::*;

  // stage 1
  logic v1;
  logic [COL_W-1:0]  col1, row1;
  logic [TIME_W-1:0] t1;
  // stage 2
  logic v2;
  logic [17:0] sqx2;
  logic [19:0] sqy2;
  logic [ANGLE_W-1:0] cp1, cp2, cp3, tp1, tp2, tp3, tp4;
  logic [26:0] q0_2;
  logic [7:0]  x8_2;
  // stage 3
  logic v3;
  logic [SQ_W-1:0]    sq3;
  logic [SIDX_W-1:0]  idx1, idx2, idx3;
  logic [ANGLE_W-1:0] tt4_3;
  logic [PHASE_W-1:0] ph3;
  // stage 4
  logic v4;
  logic [SQ_W-1:0]    sq4;
  logic signed [SINE_W-1:0] sn1, sn2, sn3;
  logic [ANGLE_W-1:0] tt4_4;
  logic [PHASE_W-1:0] ph4;

  logic signed [10:0] dx, dy;
  logic signed [11:0] dyh;
  logic signed [21:0] sx;
  logic signed [23:0] sy;
  logic [28:0] x32;
  logic [58:0] pm;
  logic [ANGLE_W-1:0] a1, a2, a3;
  logic [7:0] five_q, rem8;

  always_comb begin
    dx  = signed'({2'b0, col1, 1'b0}) - signed'({2'b0, width});
    dy  = signed'({2'b0, row1, 1'b0}) - signed'({2'b0, height});
    dyh = {dy, 1'b0};
    sx  = 22'(dx) * 22'(dx);
    sy  = 24'(dyh) * 24'(dyh);
    x32 = {t1, 5'b0};
    pm  = 59'(x32) * 59'(RECIP5);
  end

  always_comb begin
    a1 = cp1 + tp1;
    a2 = cp2 + tp2;
    a3 = cp3 + tp3;
    five_q = q0_2[7:0] + {q0_2[5:0], 2'b0};
    rem8   = x8_2 - five_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    col1 <= col_in;
    row1 <= row_in;
    t1   <= time_in;

    sqx2 <= sx[17:0];
    sqy2 <= sy[19:0];
    cp1  <= ANGLE_W'(32'(col1) * 32'(F_COEF[preset][0]));
    cp2  <= ANGLE_W'(32'(row1) * 32'(F_COEF[preset][1]));
    cp3  <= ANGLE_W'(32'({1'b0, col1} + {1'b0, row1}) * 32'(F_COEF[preset][2]));
    tp1  <= ANGLE_W'((47'(t1) * 47'(S_COEF[preset][0])) >> 12);
    tp2  <= ANGLE_W'((47'(t1) * 47'(S_COEF[preset][1])) >> 12);
    tp3  <= ANGLE_W'((47'(t1) * 47'(S_COEF[preset][2])) >> 12);
    tp4  <= ANGLE_W'((47'(t1) * 47'(S_COEF[preset][3])) >> 12);
    q0_2 <= pm[58:32];
    x8_2 <= x32[7:0];

    sq3   <= SQ_W'(sqx2) + SQ_W'(sqy2);
    idx1  <= a1[ANGLE_W-1 -: SIDX_W];
    idx2  <= a2[ANGLE_W-1 -: SIDX_W];
    idx3  <= a3[ANGLE_W-1 -: SIDX_W];
    tt4_3 <= tp4;
    // bump the quotient estimate when the remainder shows it low by one
    ph3   <= q0_2[PHASE_W-1:0] + PHASE_W'(rem8 >= 8'd5);

    sq4   <= sq3;
    sn1   <= sine_at(idx1);
    sn2   <= sine_at(idx2);
    sn3   <= sine_at(idx3);
    tt4_4 <= tt4_3;
    ph4   <= ph3;

    sq_out          <= sq4;
    side_out.sum3   <= SUM3_W'(sn1) + SUM3_W'(sn2) + SUM3_W'(sn3);
    side_out.phase  <= ph4;
    side_out.tterm4 <= tt4_4;
  end

endmodule
`default_nettype wire

// ----- design/ppg_isqrt.sv -----
// Pipelined integer square root of (sq << 16), one result bit per stage.
// Carries the side data of each item alongside. Depends on ppg_pkg.
`default_nettype none
module ppg_isqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [ppg_pkg::SQ_W-1:0]   sq_in,
  input  ppg_pkg::side_t                  side_in,
  output logic                            out_valid,
  output logic [ppg_pkg::DIST_W-1:0]      dist_out,
  output ppg_pkg::side_t                  side_out
);
  import ppg_pkg::*;

  localparam int RW = 2 * ISQRT_STEPS - 1;

  logic          vld  [ISQRT_STEPS];
  logic [RW-1:0] rem  [ISQRT_STEPS];
  logic [RW-1:0] root [ISQRT_STEPS];
  side_t         side [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam int BP = 2 * (ISQRT_STEPS - 1 - k);
    logic          v_cur;
    logic [RW-1:0] n_cur, r_cur, trial;
    side_t         s_cur;

    if (k == 0) begin : g_first
      always_comb begin
        v_cur = in_valid;
        n_cur = RW'({sq_in, 16'b0});
        r_cur = '0;
        s_cur = side_in;
      end
    end else begin : g_rest
      always_comb begin
        v_cur = vld[k-1];
        n_cur = rem[k-1];
        r_cur = root[k-1];
        s_cur = side[k-1];
      end
    end

    assign trial = r_cur + (RW'(1) << BP);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_cur;
      end
    end

    always_ff @(posedge clk) begin
      side[k] <= s_cur;
      if (n_cur >= trial) begin
        rem[k]  <= n_cur - trial;
        root[k] <= (r_cur >> 1) + (RW'(1) << BP);
      end else begin
        rem[k]  <= n_cur;
        root[k] <= r_cur >> 1;
      end
    end
  end

  assign out_valid = vld[ISQRT_STEPS-1];
  assign dist_out  = root[ISQRT_STEPS-1][DIST_W-1:0];
  assign side_out  = side[ISQRT_STEPS-1];

endmodule
`default_nettype wire

// ----- design/ppg_back.sv -----
// Back stages: radial angle, fourth sine, value plus phase, slot and theme
// lookup into the result registers. Depends on ppg_pkg.
`default_nettype none
module ppg_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [ppg_pkg::DIST_W-1:0]  dist_in,
  input  ppg_pkg::side_t                   side_in,
  input  wire logic [1:0]                  preset,
  input  wire logic [1:0]                  theme,
  output logic                             done,
  output logic [ppg_pkg::SLOT_W-1:0]       slot,
  output logic [2:0]                       colour,
  output logic [1:0]                       bright,
  output logic [7:0]                       glyph
);
  import ppg_pkg::*;

  logic v1, v2, v3, v4;
  side_t s1, s2, s3;
  logic [ANGLE_W-1:0] a4p;
  logic [SIDX_W-1:0]  idx4;
  logic signed [SINE_W-1:0] sn4;
  logic [SLOT_W-1:0] slot4;

  logic [41:0] m4;
  logic [ANGLE_W-1:0] a4;
  logic [18:0] tot;
  logic [20:0] scaled;
  logic [SLOT_W-1:0] pick;
  stop_t st;

  always_comb begin
    m4  = 42'(dist_in) * 42'(F_COEF[preset][3]);
    a4  = a4p + s1.tterm4;
    tot = 19'(s3.sum3) + 19'(sn4) + 19'd65536 + 19'(s3.phase);
    scaled = 21'(tot[16:0]) * 21'(PALETTE_ENTRIES);
    pick = (slot4 > SLOT_W'(PALETTE_ENTRIES - 1)) ? SLOT_W'(PALETTE_ENTRIES - 1) : slot4;
    st   = THEMES[theme][pick];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    a4p  <= m4[32:9];
    s1   <= side_in;
    idx4 <= a4[ANGLE_W-1 -: SIDX_W];
    s2   <= s1;
    sn4  <= sine_at(idx4);
    s3   <= s2;
    slot4  <= scaled[20:17];
    slot   <= pick;
    colour <= st.colour;
    bright <= st.bright;
    glyph  <= st.glyph;
  end

endmodule
`default_nettype wire
